[src/tpca_pkg.sv]
// Shared types and constants of the touch point calibrate and average block.
package tpca_pkg;

	localparam int RAW_W         = 12;
	localparam int PIX_W         = 11;
	localparam int ORI_W         = 3;
	localparam int HISTORY_DEPTH = 4;
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W         = PIX_W + FILL_W;
	localparam int PROD_W        = RAW_W + PIX_W;
	localparam int CNT_W         = $clog2(PROD_W + 1);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [RAW_W-1:0] X_MIN_RST  = RAW_W'(200);
	localparam logic [RAW_W-1:0] X_MAX_RST  = RAW_W'(3750);
	localparam logic [RAW_W-1:0] Y_MIN_RST  = RAW_W'(260);
	localparam logic [RAW_W-1:0] Y_MAX_RST  = RAW_W'(3860);
	localparam logic [PIX_W-1:0] H_RES_RST  = PIX_W'(320);
	localparam logic [PIX_W-1:0] V_RES_RST  = PIX_W'(240);
	localparam logic [ORI_W-1:0] ORIENT_RST = ORI_W'(6);

	localparam int ORI_SWAP     = 0;
	localparam int ORI_MIRROR_X = 1;
	localparam int ORI_MIRROR_Y = 2;

	typedef enum logic [2:0] {
		REG_X_RAW_MIN   = 3'd0,
		REG_X_RAW_MAX   = 3'd1,
		REG_Y_RAW_MIN   = 3'd2,
		REG_Y_RAW_MAX   = 3'd3,
		REG_H_PIXELS    = 3'd4,
		REG_V_PIXELS    = 3'd5,
		REG_ORIENTATION = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
		logic [PIX_W-1:0] h_res;
		logic [PIX_W-1:0] v_res;
		logic [ORI_W-1:0] orient;
	} cfg_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MAP    = 8'b0000_0010,
		ST_SCALE  = 8'b0000_0100,
		ST_PUSH   = 8'b0000_1000,
		ST_SUM    = 8'b0001_0000,
		ST_AVG_GO = 8'b0010_0000,
		ST_AVG    = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic release_pt;
		logic scale_start;
		logic push;
		logic sum_step;
		logic avg_start;
		logic avg_done;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sum_last;
	} dp_sts_t;

endpackage

[src/tpca_if.sv]
// Sample and point channel interfaces.
interface tpca_sample_if import tpca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pen_down;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, pen_down, raw_x, raw_y, input ready);
	modport sink (input valid, pen_down, raw_x, raw_y, output ready);
endinterface

interface tpca_point_if import tpca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pressed;
	logic [PIX_W-1:0] point_x;
	logic [PIX_W-1:0] point_y;

	modport source (output valid, pressed, point_x, point_y, input ready);
	modport sink (input valid, pressed, point_x, point_y, output ready);
endinterface

[src/tpca_regs.sv]
// APB configuration registers.
module tpca_regs import tpca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min  <= X_MIN_RST;
			cfg_q.x_max  <= X_MAX_RST;
			cfg_q.y_min  <= Y_MIN_RST;
			cfg_q.y_max  <= Y_MAX_RST;
			cfg_q.h_res  <= H_RES_RST;
			cfg_q.v_res  <= V_RES_RST;
			cfg_q.orient <= ORIENT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_X_RAW_MIN:   cfg_q.x_min  <= pwdata[RAW_W-1:0];
				REG_X_RAW_MAX:   cfg_q.x_max  <= pwdata[RAW_W-1:0];
				REG_Y_RAW_MIN:   cfg_q.y_min  <= pwdata[RAW_W-1:0];
				REG_Y_RAW_MAX:   cfg_q.y_max  <= pwdata[RAW_W-1:0];
				REG_H_PIXELS:    cfg_q.h_res  <= pwdata[PIX_W-1:0];
				REG_V_PIXELS:    cfg_q.v_res  <= pwdata[PIX_W-1:0];
				REG_ORIENTATION: cfg_q.orient <= pwdata[ORI_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_X_RAW_MIN:   prdata = DATA_W'(cfg_q.x_min);
			REG_X_RAW_MAX:   prdata = DATA_W'(cfg_q.x_max);
			REG_Y_RAW_MIN:   prdata = DATA_W'(cfg_q.y_min);
			REG_Y_RAW_MAX:   prdata = DATA_W'(cfg_q.y_max);
			REG_H_PIXELS:    prdata = DATA_W'(cfg_q.h_res);
			REG_V_PIXELS:    prdata = DATA_W'(cfg_q.v_res);
			REG_ORIENTATION: prdata = DATA_W'(cfg_q.orient);
			default:         prdata = '0;
		endcase
	end

endmodule

[src/tpca_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module tpca_div import tpca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [RAW_W-1:0]  divisor,
	output logic              busy,
	output logic [PROD_W-1:0] quotient
);

	logic [RAW_W-1:0]  rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [RAW_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [RAW_W:0]    trial;
	logic [RAW_W:0]    diff;
	logic              ge;

	assign trial    = {rem_q, quo_q[PROD_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

endmodule

[src/tpca_dp.sv]
// Datapath: axis mapping, history window, averaging and result register.
module tpca_dp import tpca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic             pen_down,
	input  logic [RAW_W-1:0] raw_x,
	input  logic [RAW_W-1:0] raw_y,
	output logic             pressed,
	output logic [PIX_W-1:0] point_x,
	output logic [PIX_W-1:0] point_y
);

	logic             pressed_q;
	logic [RAW_W-1:0] a_q;
	logic [RAW_W-1:0] b_q;
	logic [PIX_W-1:0] hist_x_q [HISTORY_DEPTH];
	logic [PIX_W-1:0] hist_y_q [HISTORY_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;
	logic [PIX_W-1:0] held_x_q;
	logic [PIX_W-1:0] held_y_q;
	logic             out_pressed_q;
	logic [PIX_W-1:0] out_x_q;
	logic [PIX_W-1:0] out_y_q;

	logic [RAW_W-1:0]  off_x, off_y, span_x, span_y;
	logic [PROD_W-1:0] prod_x, prod_y;
	logic [PROD_W-1:0] dvd_x, dvd_y;
	logic [RAW_W-1:0]  dvs_x, dvs_y;
	logic              busy_x, busy_y;
	logic [PROD_W-1:0] quo_x, quo_y;
	logic [PIX_W-1:0]  sat_x, sat_y, px, py;

	assign off_x  = (a_q > cfg.x_min) ? a_q - cfg.x_min : '0;
	assign off_y  = (b_q > cfg.y_min) ? b_q - cfg.y_min : '0;
	assign span_x = (cfg.x_max > cfg.x_min) ? cfg.x_max - cfg.x_min : RAW_W'(1);
	assign span_y = (cfg.y_max > cfg.y_min) ? cfg.y_max - cfg.y_min : RAW_W'(1);
	assign prod_x = PROD_W'(off_x) * PROD_W'(cfg.h_res);
	assign prod_y = PROD_W'(off_y) * PROD_W'(cfg.v_res);

	assign dvd_x = cmd.avg_start ? PROD_W'(sum_x_q) : prod_x;
	assign dvd_y = cmd.avg_start ? PROD_W'(sum_y_q) : prod_y;
	assign dvs_x = cmd.avg_start ? RAW_W'(fill_q) : span_x;
	assign dvs_y = cmd.avg_start ? RAW_W'(fill_q) : span_y;

	tpca_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.scale_start | cmd.avg_start),
		.dividend (dvd_x),
		.divisor  (dvs_x),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	tpca_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.scale_start | cmd.avg_start),
		.dividend (dvd_y),
		.divisor  (dvs_y),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	// saturate to the resolution, then mirror
	assign sat_x = (quo_x > PROD_W'(cfg.h_res)) ? cfg.h_res : quo_x[PIX_W-1:0];
	assign sat_y = (quo_y > PROD_W'(cfg.v_res)) ? cfg.v_res : quo_y[PIX_W-1:0];
	assign px    = cfg.orient[ORI_MIRROR_X] ? cfg.h_res - sat_x : sat_x;
	assign py    = cfg.orient[ORI_MIRROR_Y] ? cfg.v_res - sat_y : sat_y;

	assign sts.div_busy = busy_x | busy_y;
	assign sts.sum_last = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;

	assign pressed = out_pressed_q;
	assign point_x = out_x_q;
	assign point_y = out_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else begin
			if (cmd.release_pt) begin
				fill_q <= '0;
			end else if (cmd.push && fill_q < FILL_W'(HISTORY_DEPTH)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.avg_done) begin
				held_x_q <= quo_x[PIX_W-1:0];
				held_y_q <= quo_y[PIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pressed_q <= pen_down;
			a_q       <= cfg.orient[ORI_SWAP] ? raw_y : raw_x;
			b_q       <= cfg.orient[ORI_SWAP] ? raw_x : raw_y;
		end
		if (cmd.push) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
			end
			hist_x_q[0] <= px;
			hist_y_q[0] <= py;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			idx_q       <= '0;
		end
		if (cmd.sum_step) begin
			sum_x_q <= sum_x_q + SUM_W'(hist_x_q[idx_q]);
			sum_y_q <= sum_y_q + SUM_W'(hist_y_q[idx_q]);
			idx_q   <= idx_q + IDX_W'(1);
		end
		if (cmd.out_load) begin
			out_pressed_q <= pressed_q;
			out_x_q       <= held_x_q;
			out_y_q       <= held_y_q;
		end
	end

endmodule

[src/tpca_ctrl.sv]
// Controller state machine and output valid flag.
module tpca_ctrl import tpca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_pen_down,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_pen_down) begin
						state_d = ST_MAP;
					end else begin
						cmd.release_pt = 1'b1;
						state_d        = ST_EMIT;
					end
				end
			end
			ST_MAP: begin
				cmd.scale_start = 1'b1;
				state_d         = ST_SCALE;
			end
			ST_SCALE: begin
				if (!sts.div_busy) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) state_d = ST_AVG_GO;
			end
			ST_AVG_GO: begin
				cmd.avg_start = 1'b1;
				state_d       = ST_AVG;
			end
			ST_AVG: begin
				if (!sts.div_busy) begin
					cmd.avg_done = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/touch_point_calibrate_average_unit.sv]
// Touch point calibrate and average: top level.
//
// sample channel (sink): one transfer per touch sample with pen_down, raw_x
// and raw_y. point channel (source): exactly one transfer per sample with
// pressed, point_x and point_y in pixels.
// APB port: seven calibration registers at byte offsets 0x00..0x18; the user
// must write them only while the block is idle, which the block itself does
// not enforce; pready is always high.
// Pen down: the sample is mapped to pixels on both axes and averaged with
// up to HISTORY_DEPTH - 1 earlier points of the current press. One 23-step
// serial divider per axis runs twice (scaling, then averaging); the next
// sample is taken the cycle after the result is loaded into the output
// register. Pen up: the window is emptied and the last point is repeated.
// Reset restores the register defaults, empties the window and zeroes the
// held point. A stalled receiver keeps the result in the output register;
// the block still takes and works on the next sample, then waits for the
// register to drain before loading the next result.
module touch_point_calibrate_average_unit import tpca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tpca_sample_if.sink       sample,
	tpca_point_if.source      point,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	tpca_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample.valid),
		.in_pen_down (sample.pen_down),
		.in_ready    (sample.ready),
		.out_valid   (point.valid),
		.out_ready   (point.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	tpca_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.pen_down (sample.pen_down),
		.raw_x    (sample.raw_x),
		.raw_y    (sample.raw_y),
		.pressed  (point.pressed),
		.point_x  (point.point_x),
		.point_y  (point.point_y)
	);

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the touch point calibrate and average unit.
module testbench import tpca_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             pressed;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic              is_write;
		reg_idx_t          sel;
		logic [DATA_W-1:0] value;
		logic              pen;
		logic [RAW_W-1:0]  rx;
		logic [RAW_W-1:0]  ry;
		logic              typed;
		logic [PIX_W-1:0]  ex;
		logic [PIX_W-1:0]  ey;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 45;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 70;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	tpca_sample_if sample_ch ();
	tpca_point_if  point_ch ();

	touch_point_calibrate_average_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.point   (point_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	cfg_t             shadow_cfg;
	logic [PIX_W-1:0] hist_x [HISTORY_DEPTH];
	logic [PIX_W-1:0] hist_y [HISTORY_DEPTH];
	int               fill;
	logic [PIX_W-1:0] held_x;
	logic [PIX_W-1:0] held_y;
	point_t           pending_points [$];
	int               errors = 0;
	logic             calm = 1'b0;
	stim_row_t        directed_rows [DIRECTED_ROWS];

	task automatic flag_error(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [PIX_W-1:0] to_pixels(input logic [RAW_W-1:0] raw,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
			input logic [PIX_W-1:0] res, input logic mirror);
		int unsigned offset, span, scaled;
		offset = (raw > lo) ? 32'(raw) - 32'(lo) : 0;
		span   = (hi > lo) ? 32'(hi) - 32'(lo) : 1;
		scaled = (offset * 32'(res)) / span;
		if (scaled > 32'(res))
			scaled = 32'(res);
		if (mirror)
			scaled = 32'(res) - scaled;
		return scaled[PIX_W-1:0];
	endfunction

	// pen down: map, push into the window, average; pen up: empty window, repeat point
	task automatic track_sample(input logic pen, input logic [RAW_W-1:0] rx,
			input logic [RAW_W-1:0] ry, output point_t pt);
		logic [RAW_W-1:0] a, b;
		int unsigned      sx, sy;
		if (pen) begin
			a = shadow_cfg.orient[ORI_SWAP] ? ry : rx;
			b = shadow_cfg.orient[ORI_SWAP] ? rx : ry;
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				hist_x[i] = hist_x[i-1];
				hist_y[i] = hist_y[i-1];
			end
			hist_x[0] = to_pixels(a, shadow_cfg.x_min, shadow_cfg.x_max, shadow_cfg.h_res,
				shadow_cfg.orient[ORI_MIRROR_X]);
			hist_y[0] = to_pixels(b, shadow_cfg.y_min, shadow_cfg.y_max, shadow_cfg.v_res,
				shadow_cfg.orient[ORI_MIRROR_Y]);
			if (fill < HISTORY_DEPTH)
				fill++;
			sx = 0;
			sy = 0;
			for (int i = 0; i < fill; i++) begin
				sx += hist_x[i];
				sy += hist_y[i];
			end
			held_x = PIX_W'(sx / fill);
			held_y = PIX_W'(sy / fill);
		end else begin
			fill = 0;
		end
		pt.pressed = pen;
		pt.x       = held_x;
		pt.y       = held_y;
	endtask

	function automatic logic [DATA_W-1:0] shadow_value(input reg_idx_t r);
		case (r)
			REG_X_RAW_MIN:   return DATA_W'(shadow_cfg.x_min);
			REG_X_RAW_MAX:   return DATA_W'(shadow_cfg.x_max);
			REG_Y_RAW_MIN:   return DATA_W'(shadow_cfg.y_min);
			REG_Y_RAW_MAX:   return DATA_W'(shadow_cfg.y_max);
			REG_H_PIXELS:    return DATA_W'(shadow_cfg.h_res);
			REG_V_PIXELS:    return DATA_W'(shadow_cfg.v_res);
			REG_ORIENTATION: return DATA_W'(shadow_cfg.orient);
			default:         return '0;
		endcase
	endfunction

	task automatic write_register(input reg_idx_t r, input logic [DATA_W-1:0] v);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = ADDR_W'(4 * int'(r));
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_X_RAW_MIN:   shadow_cfg.x_min  = v[RAW_W-1:0];
			REG_X_RAW_MAX:   shadow_cfg.x_max  = v[RAW_W-1:0];
			REG_Y_RAW_MIN:   shadow_cfg.y_min  = v[RAW_W-1:0];
			REG_Y_RAW_MAX:   shadow_cfg.y_max  = v[RAW_W-1:0];
			REG_H_PIXELS:    shadow_cfg.h_res  = v[PIX_W-1:0];
			REG_V_PIXELS:    shadow_cfg.v_res  = v[PIX_W-1:0];
			REG_ORIENTATION: shadow_cfg.orient = v[ORI_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== shadow_value(r))
			flag_error($sformatf("register %s read %0d want %0d", r.name(), prdata,
				shadow_value(r)));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_sample(input logic pen, input logic [RAW_W-1:0] rx,
			input logic [RAW_W-1:0] ry, input logic typed = 1'b0,
			input logic [PIX_W-1:0] ex = '0, input logic [PIX_W-1:0] ey = '0);
		int     gap;
		point_t pt;
		gap = calm ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid    = 1'b1;
		sample_ch.pen_down = pen;
		sample_ch.raw_x    = rx;
		sample_ch.raw_y    = ry;
		do @(posedge clk); while (!sample_ch.ready);
		track_sample(pen, rx, ry, pt);
		if (typed) begin
			pt.x = ex;
			pt.y = ey;
		end
		pending_points.push_back(pt);
	endtask

	// sender holds off until every point is back, then a short settle
	task automatic wait_drained();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo,
			input logic [RAW_W-1:0] hi);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return lo;
			3:       return hi;
			default: return RAW_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_bound();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return RAW_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_res();
		case ($urandom_range(0, 9))
			0:       return PIX_W'(1);
			1:       return '1;
			default: return PIX_W'($urandom_range(1, 2047));
		endcase
	endfunction

	task automatic randomize_calibration();
		logic [RAW_W-1:0] a, b, t;
		a = pick_bound();
		b = pick_bound();
		if ($urandom_range(0, 9) < 7 && a > b) begin
			t = a;
			a = b;
			b = t;
		end
		write_register(REG_X_RAW_MIN, DATA_W'(a));
		write_register(REG_X_RAW_MAX, DATA_W'(b));
		a = pick_bound();
		b = pick_bound();
		if ($urandom_range(0, 9) < 7 && a > b) begin
			t = a;
			a = b;
			b = t;
		end
		write_register(REG_Y_RAW_MIN, DATA_W'(a));
		write_register(REG_Y_RAW_MAX, DATA_W'(b));
		write_register(REG_H_PIXELS, DATA_W'(pick_res()));
		write_register(REG_V_PIXELS, DATA_W'(pick_res()));
		write_register(REG_ORIENTATION, DATA_W'($urandom_range(0, 7)));
	endtask

	function automatic stim_row_t row_write(input reg_idx_t r, input int v);
		stim_row_t row;
		row          = '0;
		row.is_write = 1'b1;
		row.sel      = r;
		row.value    = DATA_W'(v);
		return row;
	endfunction

	function automatic stim_row_t row_sample(input logic pen, input int rx, input int ry);
		stim_row_t row;
		row     = '0;
		row.sel = REG_X_RAW_MIN;
		row.pen = pen;
		row.rx  = RAW_W'(rx);
		row.ry  = RAW_W'(ry);
		return row;
	endfunction

	function automatic stim_row_t row_checked(input logic pen, input int rx, input int ry,
			input int ex, input int ey);
		stim_row_t row;
		row       = row_sample(pen, rx, ry);
		row.typed = 1'b1;
		row.ex    = PIX_W'(ex);
		row.ey    = PIX_W'(ey);
		return row;
	endfunction

	always @(posedge clk) begin : point_check
		point_t want;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			if (pending_points.size() == 0) begin
				flag_error($sformatf("unexpected point transfer %0d/%0d/%0d",
					point_ch.pressed, point_ch.point_x, point_ch.point_y));
			end else begin
				want = pending_points.pop_front();
				if (point_ch.pressed !== want.pressed)
					flag_error($sformatf("pressed got %0d want %0d", point_ch.pressed,
						want.pressed));
				if (point_ch.point_x !== want.x)
					flag_error($sformatf("point_x got %0d want %0d", point_ch.point_x, want.x));
				if (point_ch.point_y !== want.y)
					flag_error($sformatf("point_y got %0d want %0d", point_ch.point_y, want.y));
			end
		end
	end

	initial begin : point_sink
		int hold;
		hold           = 0;
		point_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				point_ch.ready = 1'b0;
				hold--;
			end else begin
				point_ch.ready = 1'b1;
				if (!calm)
					hold = idle_len();
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int burst;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.pen_down = 1'b0;
		sample_ch.raw_x    = '0;
		sample_ch.raw_y    = '0;
		shadow_cfg         = '{X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST, H_RES_RST,
			V_RES_RST, ORIENT_RST};
		fill               = 0;
		held_x             = '0;
		held_y             = '0;
		foreach (hist_x[i]) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
		end

		directed_rows = '{
			row_checked(0, 4095, 4095, 0, 0),
			row_checked(1, 0, 0, 320, 240),
			row_checked(1, 4095, 4095, 160, 120),
			row_checked(1, 200, 260, 213, 160),
			row_checked(1, 3750, 3860, 160, 120),
			row_sample(1, 1975, 2060),
			row_sample(0, 0, 0),
			row_sample(0, 4095, 4095),
			row_write(REG_ORIENTATION, 0),
			row_sample(1, 1000, 2000),
			row_sample(1, 'hAAA, 'h555),
			row_write(REG_ORIENTATION, 1),
			row_sample(1, 300, 3000),
			row_write(REG_ORIENTATION, 7),
			row_sample(1, 4095, 0),
			row_sample(0, 'h555, 'hAAA),
			// equal bounds on X, min above max on Y
			row_write(REG_X_RAW_MIN, 3000),
			row_write(REG_X_RAW_MAX, 3000),
			row_write(REG_Y_RAW_MIN, 4095),
			row_write(REG_Y_RAW_MAX, 0),
			row_write(REG_ORIENTATION, 0),
			row_write(REG_H_PIXELS, 2047),
			row_write(REG_V_PIXELS, 2047),
			row_checked(1, 3001, 0, 2047, 0),
			row_checked(1, 2999, 4095, 1023, 0),
			row_sample(0, 0, 0),
			// zero resolution, mirrored
			row_write(REG_X_RAW_MIN, 0),
			row_write(REG_X_RAW_MAX, 4095),
			row_write(REG_Y_RAW_MIN, 0),
			row_write(REG_Y_RAW_MAX, 4095),
			row_write(REG_H_PIXELS, 0),
			row_write(REG_V_PIXELS, 0),
			row_write(REG_ORIENTATION, 6),
			row_checked(1, 4095, 4095, 0, 0),
			row_checked(1, 1234, 3210, 0, 0),
			row_sample(0, 0, 0),
			row_write(REG_H_PIXELS, 2047),
			row_write(REG_V_PIXELS, 2047),
			row_write(REG_ORIENTATION, 0),
			row_checked(1, 4095, 4095, 2047, 2047),
			row_checked(1, 1, 1, 1023, 1023),
			row_sample(1, 2048, 2048),
			row_sample(1, 4095, 0),
			row_sample(1, 'h555, 'hAAA),
			row_sample(0, 0, 0)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				wait_drained();
				write_register(directed_rows[i].sel, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i].pen, directed_rows[i].rx, directed_rows[i].ry,
					directed_rows[i].typed, directed_rows[i].ex, directed_rows[i].ey);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			randomize_calibration();
			calm = (phase == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_sample(1'($urandom_range(0, 1)), RAW_W'($urandom_range(0, 4095)),
						RAW_W'($urandom_range(0, 4095)));
					sent++;
				end else begin
					burst = $urandom_range(1, 10);
					repeat (burst)
						send_sample(1'b1, pick_raw(shadow_cfg.x_min, shadow_cfg.x_max),
							pick_raw(shadow_cfg.y_min, shadow_cfg.y_max));
					send_sample(1'b0, RAW_W'($urandom_range(0, 4095)),
						RAW_W'($urandom_range(0, 4095)));
					sent += burst + 1;
				end
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
src/tpca_pkg.sv
src/tpca_if.sv
src/tpca_regs.sv
src/tpca_div.sv
src/tpca_dp.sv
src/tpca_ctrl.sv
src/touch_point_calibrate_average_unit.sv
tb/sv/testbench.sv
